### hdl/pal_pkg.sv
// package for the palette find-or-insert block
// holds transaction types, operation codes and parameter defaults; no dependencies
package pal_pkg;

  localparam int CAPACITY_DEF      = 256;
  localparam int MATERIAL_BITS_DEF = 16;
  localparam int FLAG_BITS_DEF     = 16;

  localparam int FIELD_W = 16;
  localparam int INDEX_W = 8;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [FIELD_W-1:0] material;
    logic [FIELD_W-1:0] flags;
    logic [INDEX_W-1:0] index;
  } req_item_t;

  typedef struct packed {
    logic               ok;
    logic [INDEX_W-1:0] palette_index;
    logic [FIELD_W-1:0] out_material;
    logic [FIELD_W-1:0] out_flags;
  } rsp_item_t;

endpackage

### hdl/pal_store.sv
// palette entry memory: one write port, one registered read port
// entry 0 is the fixed zero block and always reads as zero; no package use
module pal_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] mem_q;
  logic             rd_zero;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q   <= mem[rd_addr];
      rd_zero <= (rd_addr == '0);
    end
  end

  // entry 0 is never written, so substitute the zero block
  assign rd_data = rd_zero ? '0 : mem_q;

endmodule

### hdl/palette_find_or_insert.sv
// Palette dictionary of up to CAPACITY material/flags pairs, entry 0 fixed to the zero
// block. One transaction is handled at a time. An encode compares one stored entry per
// cycle against the request, from index 0 upward, through the single read port of the
// entry memory. The scan stops at the first hit, or after the last used entry on a miss
// or a full palette, and the next request is taken once the result has moved into the
// response register. A decode reads the addressed entry once. The response register lets
// a new request in while a result still waits; a second finished result holds the input
// stalled until the first is taken.
// depends on pal_pkg and pal_store
module palette_find_or_insert #(
  parameter int CAPACITY      = pal_pkg::CAPACITY_DEF,
  parameter int MATERIAL_BITS = pal_pkg::MATERIAL_BITS_DEF,
  parameter int FLAG_BITS     = pal_pkg::FLAG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  pal_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output pal_pkg::rsp_item_t rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENT_W = MATERIAL_BITS + FLAG_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]               state;
  logic [MATERIAL_BITS-1:0] mat;
  logic [FLAG_BITS-1:0]     flg;
  logic [pal_pkg::INDEX_W-1:0] idx;
  logic                     dec_used;
  logic [IDX_W-1:0]         scan;
  logic [CNT_W-1:0]         count;
  pal_pkg::rsp_item_t       res;

  logic                     accept;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [ENT_W-1:0]         rd_data;
  logic                     wr_en;
  logic                     hit;
  logic                     last;
  logic                     has_room;
  logic                     rsp_load;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign hit       = (rd_data == {mat, flg});
  assign last      = ((CNT_W'(scan) + CNT_W'(1)) == count);
  assign has_room  = (count < CNT_W'(CAPACITY));
  assign wr_en     = (state == S_SCAN) && !hit && last && has_room;
  assign rsp_load  = (state == S_OUT) && (!rsp_valid || !rsp_stall);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        rd_en   = accept;
        rd_addr = (req.operation == pal_pkg::OP_DECODE) ? IDX_W'(req.index) : '0;
      end
      S_SCAN: begin
        rd_en   = !hit && !last;
        rd_addr = scan + IDX_W'(1);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  pal_store #(
    .DEPTH (CAPACITY),
    .WIDTH (ENT_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data ({mat, flg})
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= CNT_W'(1);
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (req.operation == pal_pkg::OP_DECODE) ? S_DEC : S_SCAN;
          end
        end
        S_DEC: begin
          state <= S_OUT;
        end
        S_SCAN: begin
          if (hit || last) begin
            state <= S_OUT;
          end
          if (wr_en) begin
            count <= count + CNT_W'(1);
          end
        end
        S_OUT: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture and result assembly
  always_ff @(posedge clk) begin
    if (accept) begin
      mat      <= MATERIAL_BITS'(req.material);
      flg      <= FLAG_BITS'(req.flags);
      idx      <= req.index;
      dec_used <= ({1'b0, req.index} < 9'(count));
      scan     <= '0;
    end
    if (state == S_SCAN && !hit && !last) begin
      scan <= scan + IDX_W'(1);
    end
    if (state == S_DEC) begin
      res.ok            <= 1'b1;
      res.palette_index <= idx;
      res.out_material  <= dec_used ?
                           pal_pkg::FIELD_W'(rd_data[ENT_W-1:FLAG_BITS]) : '0;
      res.out_flags     <= dec_used ? pal_pkg::FIELD_W'(rd_data[FLAG_BITS-1:0]) : '0;
    end
    if (state == S_SCAN && hit) begin
      res.ok            <= 1'b1;
      res.palette_index <= pal_pkg::INDEX_W'(scan);
      res.out_material  <= pal_pkg::FIELD_W'(mat);
      res.out_flags     <= pal_pkg::FIELD_W'(flg);
    end else if (state == S_SCAN && last) begin
      res.ok            <= has_room;
      res.palette_index <= has_room ? pal_pkg::INDEX_W'(count) : '0;
      res.out_material  <= has_room ? pal_pkg::FIELD_W'(mat) : '0;
      res.out_flags     <= has_room ? pal_pkg::FIELD_W'(flg) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

endmodule

### hdl/pal_checker.sv
// port-level checks for palette_find_or_insert, attached by bind
// depends on pal_pkg
module pal_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input pal_pkg::req_item_t req,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input pal_pkg::rsp_item_t rsp
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // one transaction at a time: busy right after an accepted request
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request channel not busy after a transaction");

  // a failed encode carries an all-zero payload
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.palette_index == '0 && rsp.out_material == '0
                             && rsp.out_flags == '0)
    else $error("failed encode with non-zero payload");

  // a new response only follows work in progress
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without a transaction in progress");

endmodule

bind palette_find_or_insert pal_checker u_pal_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
